// File: design/cqkm_pkg.sv
// ----------------------------------------------------------------------------
// cqkm_pkg: shared definitions for the compacting queue with key match
// Sizes, field widths, operation and status codes, and the controller to
// datapath command bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package cqkm_pkg;

  localparam int unsigned DEPTH    = 16;
  localparam int unsigned MAX_SIZE = 4096;

  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned LEN_W  = $clog2(MAX_SIZE + 1);
  localparam int unsigned SIZE_W = 16;
  localparam int unsigned KEY_W  = 32;
  localparam int unsigned DEV_W  = 32;
  localparam int unsigned TYPE_W = 16;
  localparam int unsigned STMP_W = 64;
  localparam int unsigned PLD_W  = 64;

  localparam int unsigned IN_DATA_W  = 224;
  localparam int unsigned OUT_DATA_W = 232;

  typedef enum logic [1:0] {
    K_PUSH  = 2'd0,
    K_POP   = 2'd1,
    K_MATCH = 2'd2,
    K_FLUSH = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_t;

  typedef struct packed {
    logic load;
    logic exec;
  } dp_cmd_t;

endpackage

`default_nettype wire

// File: design/cqkm_ctrl.sv
// ----------------------------------------------------------------------------
// cqkm_ctrl: operation sequencer
// Takes one input beat, runs it in the datapath once the output register is
// free, and owns the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module cqkm_ctrl (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  wire               out_tready,
  output cqkm_pkg::dp_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   exec_fire;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign exec_fire  = (state_r == S_EXEC) && (!out_valid_r || out_tready);
  assign cmd.load   = in_tvalid && in_tready;
  assign cmd.exec   = exec_fire;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_fire) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// File: design/cqkm_dp.sv
// ----------------------------------------------------------------------------
// cqkm_dp: slot storage, key search and compaction
// Holds the packed slots and their fill count, compares every slot key in
// parallel, and shifts all later entries forward on a removal.
// ----------------------------------------------------------------------------
`default_nettype none

module cqkm_dp (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  cqkm_pkg::dp_cmd_t                    cmd,
  input  wire  [1:0]                           in_kind,
  input  wire  [cqkm_pkg::KEY_W-1:0]           in_key,
  input  wire  [cqkm_pkg::DEV_W-1:0]           in_dev,
  input  wire  [cqkm_pkg::TYPE_W-1:0]          in_type,
  input  wire  [cqkm_pkg::STMP_W-1:0]          in_stamp,
  input  wire  [cqkm_pkg::PLD_W-1:0]           in_payload,
  input  wire  [cqkm_pkg::SIZE_W-1:0]          in_size,
  output logic [1:0]                           out_status,
  output logic [cqkm_pkg::IDX_W-1:0]           out_slot,
  output logic [cqkm_pkg::LEN_W-1:0]           out_length,
  output logic [cqkm_pkg::KEY_W-1:0]           out_client,
  output logic [cqkm_pkg::DEV_W-1:0]           out_device,
  output logic [cqkm_pkg::TYPE_W-1:0]          out_type,
  output logic [cqkm_pkg::STMP_W-1:0]          out_stamp,
  output logic [cqkm_pkg::PLD_W-1:0]           out_payload,
  output logic                                 out_empty
);

  localparam int unsigned D = cqkm_pkg::DEPTH;

  logic [1:0]                    kind_r;
  logic [cqkm_pkg::KEY_W-1:0]    key_r;
  logic [cqkm_pkg::DEV_W-1:0]    dev_r;
  logic [cqkm_pkg::TYPE_W-1:0]   type_r;
  logic [cqkm_pkg::STMP_W-1:0]   stamp_r;
  logic [cqkm_pkg::PLD_W-1:0]    payload_r;
  logic [cqkm_pkg::SIZE_W-1:0]   size_r;

  logic [cqkm_pkg::CNT_W-1:0]    count_r, count_nxt;

  logic [cqkm_pkg::KEY_W-1:0]    slot_client_r  [D];
  logic [cqkm_pkg::DEV_W-1:0]    slot_device_r  [D];
  logic [cqkm_pkg::TYPE_W-1:0]   slot_type_r    [D];
  logic [cqkm_pkg::STMP_W-1:0]   slot_stamp_r   [D];
  logic [cqkm_pkg::PLD_W-1:0]    slot_payload_r [D];
  logic [cqkm_pkg::LEN_W-1:0]    slot_length_r  [D];

  logic [D-1:0]                  hit;
  logic                          take_ok;
  logic [cqkm_pkg::IDX_W-1:0]    take_idx;
  logic                          full;
  logic [cqkm_pkg::LEN_W-1:0]    push_len;
  logic [cqkm_pkg::LEN_W-1:0]    take_len;
  logic                          do_push;
  logic                          do_take;

  always_comb begin
    for (int k = 0; k < D; k++) begin
      hit[k] = (k < int'(count_r)) && (slot_client_r[k] == key_r);
    end
  end

  always_comb begin
    take_ok  = 1'b0;
    take_idx = '0;
    if (kind_r == cqkm_pkg::K_POP) begin
      take_ok = (count_r != '0);
    end else if (kind_r == cqkm_pkg::K_MATCH) begin
      for (int k = D - 1; k >= 0; k--) begin
        if (hit[k]) begin
          take_ok  = 1'b1;
          take_idx = cqkm_pkg::IDX_W'(k);
        end
      end
    end
  end

  assign full     = (count_r == cqkm_pkg::CNT_W'(D));
  assign push_len = (size_r > cqkm_pkg::SIZE_W'(cqkm_pkg::MAX_SIZE)) ?
                    cqkm_pkg::LEN_W'(cqkm_pkg::MAX_SIZE) :
                    size_r[cqkm_pkg::LEN_W-1:0];
  assign take_len = (size_r < {{(cqkm_pkg::SIZE_W - cqkm_pkg::LEN_W){1'b0}},
                               slot_length_r[take_idx]}) ?
                    size_r[cqkm_pkg::LEN_W-1:0] : slot_length_r[take_idx];
  assign do_push  = cmd.exec && (kind_r == cqkm_pkg::K_PUSH) && !full;
  assign do_take  = cmd.exec && take_ok;

  always_comb begin
    count_nxt = count_r;
    if (cmd.exec) begin
      if (kind_r == cqkm_pkg::K_FLUSH) begin
        count_nxt = '0;
      end else if (do_push) begin
        count_nxt = count_r + cqkm_pkg::CNT_W'(1);
      end else if (take_ok) begin
        count_nxt = count_r - cqkm_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r    <= in_kind;
      key_r     <= in_key;
      dev_r     <= in_dev;
      type_r    <= in_type;
      stamp_r   <= in_stamp;
      payload_r <= in_payload;
      size_r    <= in_size;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_client_r[count_r[cqkm_pkg::IDX_W-1:0]]  <= key_r;
      slot_device_r[count_r[cqkm_pkg::IDX_W-1:0]]  <= dev_r;
      slot_type_r[count_r[cqkm_pkg::IDX_W-1:0]]    <= type_r;
      slot_stamp_r[count_r[cqkm_pkg::IDX_W-1:0]]   <= stamp_r;
      slot_payload_r[count_r[cqkm_pkg::IDX_W-1:0]] <= payload_r;
      slot_length_r[count_r[cqkm_pkg::IDX_W-1:0]]  <= push_len;
    end else if (do_take) begin
      for (int k = 0; k < D - 1; k++) begin
        if (cqkm_pkg::IDX_W'(k) >= take_idx) begin
          slot_client_r[k]  <= slot_client_r[k+1];
          slot_device_r[k]  <= slot_device_r[k+1];
          slot_type_r[k]    <= slot_type_r[k+1];
          slot_stamp_r[k]   <= slot_stamp_r[k+1];
          slot_payload_r[k] <= slot_payload_r[k+1];
          slot_length_r[k]  <= slot_length_r[k+1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_status  <= cqkm_pkg::ST_OK;
      out_slot    <= '0;
      out_length  <= '0;
      out_client  <= '0;
      out_device  <= '0;
      out_type    <= '0;
      out_stamp   <= '0;
      out_payload <= '0;
      out_empty   <= (count_nxt == '0);
      case (kind_r)
        cqkm_pkg::K_PUSH: begin
          if (full) begin
            out_status <= cqkm_pkg::ST_FULL;
          end else begin
            out_slot   <= count_r[cqkm_pkg::IDX_W-1:0];
            out_length <= push_len;
          end
        end
        cqkm_pkg::K_POP, cqkm_pkg::K_MATCH: begin
          if (take_ok) begin
            out_length  <= take_len;
            out_client  <= slot_client_r[take_idx];
            out_device  <= slot_device_r[take_idx];
            out_type    <= slot_type_r[take_idx];
            out_stamp   <= slot_stamp_r[take_idx];
            out_payload <= slot_payload_r[take_idx];
          end else begin
            out_status <= cqkm_pkg::ST_MISS;
          end
        end
        default: begin
          out_status <= cqkm_pkg::ST_OK;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: design/compacting_queue_with_key_match_top.sv
// ----------------------------------------------------------------------------
// compacting_queue_with_key_match_top: sixteen-slot message queue
// Packed queue of messages with push, pop, remove by client key and flush.
// ----------------------------------------------------------------------------
// The input channel carries one operation per beat: the kind in in_tuser and
// the message fields and size in in_tdata. Every operation returns exactly
// one beat on the output channel with a status in out_tuser and the removed
// entry, written slot, returned length and an empty flag in out_tdata.
// An operation has a register step that registers the beat and an execute
// step that searches all slot keys in parallel, updates the slots and loads
// the output register. The result is valid from the clock edge that ends the
// execute step. A new beat is taken only once the previous one has executed,
// so operations do not overlap.
// A beat may be accepted while the previous result still waits; it is held
// until the output register frees, so a stalled receiver stalls the input
// after one beat. Reset empties the queue and drops any pending result; slot
// contents are not cleared and are never read before being written.
// ----------------------------------------------------------------------------
`default_nettype none

module compacting_queue_with_key_match_top (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  // client_key, device_id, msg_type, stamp, payload, size
  input  wire  [cqkm_pkg::IN_DATA_W-1:0]      in_tdata,
  // kind
  input  wire  [1:0]                          in_tuser,
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  // slot_index, length_out, client_out, device_out, type_out, stamp_out,
  // payload_out, queue_empty, zero fill
  output logic [cqkm_pkg::OUT_DATA_W-1:0]     out_tdata,
  // status
  output logic [1:0]                          out_tuser
);

  cqkm_pkg::dp_cmd_t cmd;

  logic [cqkm_pkg::IDX_W-1:0]  slot;
  logic [cqkm_pkg::LEN_W-1:0]  length;
  logic [cqkm_pkg::KEY_W-1:0]  client;
  logic [cqkm_pkg::DEV_W-1:0]  device;
  logic [cqkm_pkg::TYPE_W-1:0] mtype;
  logic [cqkm_pkg::STMP_W-1:0] stamp;
  logic [cqkm_pkg::PLD_W-1:0]  payload;
  logic                        empty;

  cqkm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  cqkm_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_kind     (in_tuser),
    .in_key      (in_tdata[31:0]),
    .in_dev      (in_tdata[63:32]),
    .in_type     (in_tdata[79:64]),
    .in_stamp    (in_tdata[143:80]),
    .in_payload  (in_tdata[207:144]),
    .in_size     (in_tdata[223:208]),
    .out_status  (out_tuser),
    .out_slot    (slot),
    .out_length  (length),
    .out_client  (client),
    .out_device  (device),
    .out_type    (mtype),
    .out_stamp   (stamp),
    .out_payload (payload),
    .out_empty   (empty)
  );

  assign out_tdata = {6'd0, empty, payload, stamp, mtype, device, client, length, slot};

endmodule

`default_nettype wire

// File: design/cqkm_chk.sv
// ----------------------------------------------------------------------------
// cqkm_chk: port-level checks for the compacting queue
// Watches the output channel for stall behavior and result consistency, and the input channel for one pending beat.
// ----------------------------------------------------------------------------
`default_nettype none

module cqkm_chk (
  input wire                                 clk,
  input wire                                 rst_n,
  input wire                                 in_tvalid,
  input wire                                 in_tready,
  input wire [cqkm_pkg::IN_DATA_W-1:0]       in_tdata,
  input wire [1:0]                           in_tuser,
  input wire                                 out_tvalid,
  input wire                                 out_tready,
  input wire [cqkm_pkg::OUT_DATA_W-1:0]      out_tdata,
  input wire [1:0]                           out_tuser
);

  logic in_fire;

  assign in_fire = in_tvalid && in_tready;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("Result dropped while stalled.");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == cqkm_pkg::ST_OK || out_tuser == cqkm_pkg::ST_FULL ||
                    out_tuser == cqkm_pkg::ST_MISS))
    else $error("Illegal status code.");

  a_full_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == cqkm_pkg::ST_FULL |->
      out_tdata[224:0] == '0 && !out_tdata[225])
    else $error("Full result carries data or reports empty.");

  a_miss_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == cqkm_pkg::ST_MISS |-> out_tdata[224:0] == '0)
    else $error("Miss result carries data.");

  a_one_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("Second beat accepted before the first was executed.");

endmodule

bind compacting_queue_with_key_match_top cqkm_chk u_cqkm_chk (.*);

`default_nettype wire
